>>> design/hwm_pkg.sv
// shared types and constants for the history window block
package hwm_pkg;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACC  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_WIDTH  = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] series_index;
        logic [VAL_W-1:0] sample_value;
        logic [POS_W-1:0] slot_position;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic              read_valid;
        logic [VAL_W-1:0]  window_max;
        logic [POS_W-1:0]  current_slot;
        logic [STAT_W-1:0] status;
    } t_out_item;
endpackage

>>> design/history_window_with_max.sv
// top level of the sliding history window with running maximum
// a read, or a set/acc that keeps the max, goes through S_RD or S_UPD, S_UPD_WR and S_OUT
// a tick or an update that lowers the max rescans width*series entries, each via S_SCAN_RD and S_SCAN_CMP
// a tick at a full window first shifts (width-1)*series entries, each via S_SHIFT_RD and S_SHIFT_WR
// one transaction in flight: the next is taken once its result has left
// reset: synchronous active low, width max_slots, then a clearing pass over max_slots*series entries
module history_window_with_max #(
    parameter int unsigned MAX_SLOTS = 256,
    parameter int unsigned N_SERIES  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hwm_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output hwm_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [hwm_pkg::CFG_W-1:0] i_cfg_data
);
    import hwm_pkg::*;

    localparam int unsigned SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned SER_W   = (N_SERIES > 1) ? $clog2(N_SERIES) : 1;
    localparam int unsigned DEPTH   = MAX_SLOTS * N_SERIES;
    localparam int unsigned ADDR_W  = SLOT_W + SER_W;
    localparam int unsigned WID_W   = $clog2(MAX_SLOTS + 1);
    localparam int unsigned CNT_W   = ADDR_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_UPD_WR, S_SHIFT_RD, S_SHIFT_WR,
        S_ZERO, S_SCAN_RD, S_SCAN_CMP, S_OUT
    } t_state;

    // value memory, slot-major with series in the low address bits
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic [ADDR_W-1:0] n_raddr, n_waddr;
    logic [VAL_W-1:0] n_wdata;
    logic n_we;
    // per-slot valid marks, flops so they clear at once
    logic [MAX_SLOTS-1:0] r_vld, n_vld;

    t_state r_state, n_state;
    logic [WID_W-1:0] r_width, n_width;
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [VAL_W-1:0] r_max, n_max;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_in_item r_item, n_item;
    t_out_item r_out, n_out;
    logic r_ovalid, n_ovalid;

    logic [CNT_W-1:0] w_total;   // width*series entries in use
    logic [VAL_W-1:0] w_cmp_max;
    logic w_cmp_en;
    logic [VAL_W-1:0] w_sum;
    logic w_carry;
    logic [WID_W-1:0] w_cfg_w;
    logic w_accept;
    logic w_idx_bad;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [SLOT_W-1:0] w_scan_slot;

    assign w_total = CNT_W'(r_width * N_SERIES);
    assign w_scan_slot = SLOT_W'(r_cnt / N_SERIES);
    assign w_cmp_en = r_vld[w_scan_slot];

    hwm_maxcmp u_cmp (
        .i_a  (r_max),
        .i_b  (r_rdata),
        .i_en (w_cmp_en),
        .o_max(w_cmp_max)
    );

    assign {w_carry, w_sum} = {1'b0, r_rdata} + {1'b0, r_item.sample_value};
    assign w_cfg_w = (i_cfg_data > CFG_W'(MAX_SLOTS)) ? WID_W'(MAX_SLOTS)
                                                      : WID_W'(i_cfg_data);
    assign w_idx_bad = 32'(r_item.series_index) >= 32'(N_SERIES);
    assign w_cur_addr = ADDR_W'(r_wslot * N_SERIES + r_item.series_index);

    // a register write in the same cycle takes priority over a new transaction
    assign o_stall = (r_state != S_IDLE) || r_ovalid || i_cfg_valid;
    assign w_accept = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    // memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_rdata <= r_mem[n_raddr];
    end

    always_comb begin
        n_state = r_state; n_width = r_width; n_wslot = r_wslot; n_max = r_max;
        n_cnt = r_cnt; n_item = r_item; n_out = r_out; n_ovalid = r_ovalid;
        n_vld = r_vld;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                // zero one entry per cycle
                n_we = 1'b1; n_waddr = r_cnt[ADDR_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_data;
                    n_out = '0;
                    n_out.status = ST_OK;
                    n_cnt = '0;
                    if (r_width == '0) begin
                        n_out.status = ST_NO_WIDTH;
                        n_state = S_OUT;
                    end else if (i_data.operation == OP_TICK) begin
                        if (WID_W'(r_wslot) + 1'b1 < r_width) begin
                            n_wslot = r_wslot + 1'b1;
                            n_state = S_ZERO;
                        end else begin
                            n_wslot = SLOT_W'(r_width - 1'b1);
                            n_state = (r_width > 1) ? S_SHIFT_RD : S_ZERO;
                        end
                    end else if (i_data.operation == OP_READ) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_RD: begin
                n_raddr = ADDR_W'(r_item.slot_position * N_SERIES
                                  + r_item.series_index);
                n_state = S_UPD_WR;
            end
            S_UPD: begin
                n_raddr = w_cur_addr;
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                if (r_item.operation == OP_READ) begin
                    n_out.read_valid = (WID_W'(r_item.slot_position) < r_width)
                                       && r_vld[SLOT_W'(r_item.slot_position)];
                    if (w_idx_bad) n_out.status = ST_BAD_INDEX;
                    else if (n_out.read_valid) n_out.read_value = r_rdata;
                    n_state = S_OUT;
                end else if (w_idx_bad) begin
                    n_out.status = ST_BAD_INDEX;
                    n_state = S_OUT;
                end else begin
                    n_wdata = (r_item.operation == OP_ACC)
                              ? (w_carry ? VAL_MAX : w_sum) : r_item.sample_value;
                    n_we = 1'b1; n_waddr = w_cur_addr;
                    n_vld[r_wslot] = 1'b1;
                    n_state = S_OUT;
                    if (n_wdata >= r_max) n_max = n_wdata;
                    else if (r_rdata == r_max) begin
                        n_max = '0; n_cnt = '0; n_state = S_SCAN_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                // read entry cnt+series, write it to cnt next cycle
                n_raddr = ADDR_W'(r_cnt + N_SERIES);
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                n_we = 1'b1; n_waddr = r_cnt[ADDR_W-1:0]; n_wdata = r_rdata;
                n_cnt = r_cnt + 1'b1;
                if (n_cnt == w_total - CNT_W'(N_SERIES)) begin
                    n_vld = '0;
                    for (int i = 0; i < MAX_SLOTS - 1; i++)
                        if (WID_W'(i) < r_width - 1'b1) n_vld[i] = r_vld[i + 1];
                    n_cnt = '0;
                    n_state = S_ZERO;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_ZERO: begin
                n_we = 1'b1;
                n_waddr = ADDR_W'(r_wslot * N_SERIES + r_cnt);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_SERIES - 1)) begin
                    n_vld[r_wslot] = 1'b0;
                    n_cnt = '0; n_max = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_raddr = r_cnt[ADDR_W-1:0];
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_max = w_cmp_max;
                n_cnt = r_cnt + 1'b1;
                n_state = (n_cnt == w_total) ? S_OUT : S_SCAN_RD;
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_out.window_max = r_max;
                    n_out.current_slot = POS_W'(r_wslot);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_valid && o_cfg_ready) begin
            n_width = w_cfg_w; n_vld = '0; n_wslot = '0; n_max = '0;
            n_cnt = '0; n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_width <= WID_W'(MAX_SLOTS); r_wslot <= '0;
            r_max <= '0; r_cnt <= '0; r_ovalid <= 1'b0; r_vld <= '0;
        end else begin
            r_state <= n_state; r_width <= n_width; r_wslot <= n_wslot;
            r_max <= n_max; r_cnt <= n_cnt; r_ovalid <= n_ovalid; r_vld <= n_vld;
        end
        r_item <= n_item;
        r_out <= n_out;
    end

    // a result never shows a slot beyond the window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_width != '0 |-> WID_W'(o_data.current_slot) < r_width)
        else $error("current slot beyond width");
    // no new transaction while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept with pending result");
    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped");
endmodule

>>> design/hwm_maxcmp.sv
// compare unit of the maximum scan
module hwm_maxcmp (
    input  logic [hwm_pkg::VAL_W-1:0] i_a,
    input  logic [hwm_pkg::VAL_W-1:0] i_b,
    input  logic                      i_en,
    output logic [hwm_pkg::VAL_W-1:0] o_max
);
    import hwm_pkg::*;
    assign o_max = (i_en && (i_b > i_a)) ? i_b : i_a;
endmodule

>>> test/tb_history_window_with_max.sv
// testbench for the sliding history window with running maximum
`timescale 1ns / 1ps

module tb_history_window_with_max;
    import hwm_pkg::*;

    localparam int unsigned SLOTS  = 256;
    localparam int unsigned SERIES = 4;
    localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_item o_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    history_window_with_max u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the window state
    logic [VAL_W-1:0] hist_val [SLOTS*SERIES];
    logic             hist_ok  [SLOTS];
    int unsigned      cur_slot;
    logic [VAL_W-1:0] peak;
    int unsigned      width;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    int  mismatch_count = 0;
    bit  send_idle_en;
    bit  recv_idle_en;
    bit  holdoff_req;
    bit  holdoff_taken = 1'b0;
    int  recv_holdoff = 0;
    bit  in_taken = 1'b0;
    longint unsigned cycle_count = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter guards against a hung block
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_history_window_with_max: FAIL");
            $finish;
        end
    end

    function automatic void clear_history();
        for (int k = 0; k < SLOTS*SERIES; k++) hist_val[k] = '0;
        for (int k = 0; k < SLOTS; k++) hist_ok[k] = 1'b0;
        cur_slot = 0;
        peak = '0;
    endfunction

    function automatic void rescan_peak();
        peak = '0;
        for (int p = 0; p < width; p++) begin
            if (hist_ok[p]) begin
                for (int s = 0; s < SERIES; s++) begin
                    if (hist_val[p*SERIES+s] > peak) peak = hist_val[p*SERIES+s];
                end
            end
        end
    endfunction

    // apply one transaction to the shadow window and return its predicted result
    function automatic t_out_item window_step(t_in_item it);
        t_out_item r;
        int unsigned ix;
        logic [VAL_W-1:0] old;
        logic [VAL_W-1:0] nv;
        bit was_peak;
        r = '0;
        r.status = ST_OK;
        if (width == 0) begin
            r.status = ST_NO_WIDTH;
        end else if (it.operation == OP_TICK) begin
            if (cur_slot + 1 < width) begin
                cur_slot++;
            end else begin
                // full window: shift everything toward the oldest slot
                for (int p = 0; p + 1 < width; p++) begin
                    for (int s = 0; s < SERIES; s++)
                        hist_val[p*SERIES+s] = hist_val[(p+1)*SERIES+s];
                    hist_ok[p] = hist_ok[p+1];
                end
                cur_slot = width - 1;
            end
            for (int s = 0; s < SERIES; s++) hist_val[cur_slot*SERIES+s] = '0;
            hist_ok[cur_slot] = 1'b0;
            rescan_peak();
        end else if (it.operation == OP_READ) begin
            if (it.slot_position < width && hist_ok[it.slot_position]) r.read_valid = 1'b1;
            if (it.series_index >= SERIES) r.status = ST_BAD_INDEX;
            else if (r.read_valid)
                r.read_value = hist_val[it.slot_position*SERIES+it.series_index];
        end else if (it.series_index >= SERIES) begin
            r.status = ST_BAD_INDEX;
        end else begin
            ix = cur_slot*SERIES + it.series_index;
            old = hist_val[ix];
            was_peak = (old == peak);
            if (it.operation == OP_ACC)
                nv = (VAL_MAX - old < it.sample_value) ? VAL_MAX : old + it.sample_value;
            else
                nv = it.sample_value;
            hist_val[ix] = nv;
            hist_ok[cur_slot] = 1'b1;
            if (nv >= peak) peak = nv;
            else if (was_peak) rescan_peak();
        end
        r.window_max = peak;
        r.current_slot = cur_slot[7:0];
        return r;
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic [1:0] ix,
                                           logic [63:0] v, logic [7:0] pos);
        t_in_item it;
        it.operation = op;
        it.series_index = ix;
        it.sample_value = v;
        it.slot_position = pos;
        return it;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VAL_MAX;
            2: return VAL_MAX - $urandom_range(0, 16);
            3: return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // random item weighted toward updates and in-window reads
    function automatic t_in_item rand_item();
        logic [1:0] op;
        logic [7:0] pos;
        int unsigned r;
        r = $urandom_range(0, 99);
        op = (r < 20) ? OP_TICK : (r < 45) ? OP_SET : (r < 70) ? OP_ACC : OP_READ;
        if (width > 0 && $urandom_range(0, 3) != 0)
            pos = 8'($urandom_range(0, width - 1));
        else
            pos = 8'($urandom_range(0, 255));
        return make_item(op, 2'($urandom_range(0, 3)), rand_value(), pos);
    endfunction

    // input handshake seen at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // driver: offers queued transactions, changes inputs at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                void'(pending_items.pop_front());
            end
            if (i_valid && !in_taken) begin
                // stalled payload stays put
            end else if (pending_items.size() > 0 &&
                         !(send_idle_en && $urandom_range(0, 99) < 36)) begin
                i_valid <= 1'b1;
                i_data  <= pending_items[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        if (holdoff_req && !holdoff_taken) begin
            holdoff_taken <= 1'b1;
            recv_holdoff <= 300;
            i_stall <= 1'b1;
        end else if (recv_holdoff > 0) begin
            recv_holdoff <= recv_holdoff - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_idle_en && ($urandom_range(0, 99) < 36);
        end
    end

    // monitor: checks every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result %p", o_data);
            end else begin
                want = expected_results.pop_front();
                if (o_data.read_value !== want.read_value ||
                    o_data.read_valid !== want.read_valid ||
                    o_data.window_max !== want.window_max ||
                    o_data.current_slot !== want.current_slot ||
                    o_data.status !== want.status) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %p actual %p", want, o_data);
                end
            end
        end
    end

    // predictions are made as each transaction is queued for the driver
    task automatic push_item(t_in_item it);
        pending_items.push_back(it);
        expected_results.push_back(window_step(it));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        // allow an in-flight scan to finish before touching the register
        repeat (2200) @(posedge i_clk);
    endtask

    task automatic write_width(logic [CFG_W-1:0] w);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        width = (w > SLOTS) ? SLOTS : w;
        clear_history();
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) push_item(rand_item());
    endtask

    initial begin
        int unsigned wlist[6];
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        holdoff_req = 1'b0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        width = SLOTS;
        clear_history();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: default width, extremes, saturation
        push_item(make_item(OP_READ, 2'd0, '0, 8'd0));
        push_item(make_item(OP_SET, 2'd0, VAL_MAX - 5, 8'd0));
        push_item(make_item(OP_ACC, 2'd0, 64'd100, 8'd0));
        push_item(make_item(OP_SET, 2'd3, 64'h5555_aaaa_5555_aaaa, 8'd0));
        push_item(make_item(OP_READ, 2'd3, '0, 8'd0));
        push_item(make_item(OP_READ, 2'd0, '0, 8'd255));
        push_item(make_item(OP_SET, 2'd0, 64'd1, 8'd0));
        push_item(make_item(OP_SET, 2'd3, 64'haaaa_5555_aaaa_5555, 8'd0));
        push_item(make_item(OP_TICK, 2'd3, VAL_MAX, 8'd255));
        push_item(make_item(OP_READ, 2'd0, '0, 8'd0));
        wait_drained();

        // tiny windows expose the single-slot tick and no-width paths
        write_width(9'd1);
        push_item(make_item(OP_SET, 2'd1, 64'd7, 8'd0));
        push_item(make_item(OP_TICK, 2'd0, '0, 8'd0));
        push_item(make_item(OP_READ, 2'd1, '0, 8'd0));
        wait_drained();
        write_width(9'd0);
        push_item(make_item(OP_SET, 2'd0, 64'd9, 8'd0));
        push_item(make_item(OP_TICK, 2'd0, '0, 8'd0));
        push_item(make_item(OP_READ, 2'd0, '0, 8'd0));
        push_item(make_item(OP_ACC, 2'd0, 64'd9, 8'd0));
        wait_drained();
        write_width(9'd511);

        // long receiver hold-off while the sender keeps offering
        holdoff_req = 1'b1;
        random_phase(20);
        wait_drained();

        wlist = '{3, 2, 5, 8, 256, 17};
        foreach (wlist[w]) begin
            write_width(wlist[w][CFG_W-1:0]);
            if (w == 1) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end else begin
                send_idle_en = 1'b1;
                recv_idle_en = 1'b1;
            end
            random_phase(wlist[w] == 256 ? 50 : 90);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("tb_history_window_with_max: PASS");
        else
            $display("tb_history_window_with_max: FAIL");
        $finish;
    end
endmodule
